>>> hdl/uer_pkg.sv
package uer_pkg;

    // Echo counter width, default.
    localparam int COUNT_BITS_DEF = 24;

    // Configuration register width and reset values.
    localparam int          REG_W          = 16;
    localparam logic [15:0] TRIG_TICKS_RST = 16'd160;
    localparam logic [15:0] TPC_RST        = 16'd928;

    // Largest distance shown; anything above saturates here.
    localparam int          DIST_W   = 10;
    localparam logic [9:0]  DIST_MAX = 10'd999;

    // Shift-add-3 conversion: one step per distance bit.
    localparam int BCD_STEPS = DIST_W;

    typedef enum logic [0:0] {
        REG_TRIGGER_TICKS = 1'b0,
        REG_TICKS_PER_CM  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic start_n;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic       trigger_level;
        logic [3:0] digit_hundreds;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
        logic       done_res;
        logic       overflow;
        logic       measured_led;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic trig_set1;
        logic trig_inc;
        logic trig_clr;
        logic echo_set1;
        logic echo_inc;
        logic div_start;
        logic div_step;
        logic conv_start;
        logic bcd_step;
        logic commit;
        logic out_load;
        logic out_trig;
        logic out_done;
    } uer_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic trig_reached;
        logic step_last;
    } uer_sts_t;

endpackage

>>> hdl/uer_ctrl.sv
module uer_ctrl
    import uer_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output uer_cmd_t cmd,
    input  uer_sts_t sts
);

    typedef enum logic [2:0] {
        ST_READY,
        ST_DIV,
        ST_CONV,
        ST_BCD,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    seq_state_t st_reg, st_next;
    phase_t     phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;
    logic       accept;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (st_reg == ST_READY) && slot_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        cmd        = '0;
        st_next    = st_reg;
        phase_next = phase_reg;
        unique case (st_reg)
            ST_READY: begin
                if (accept) begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (!s_data.start_n) begin
                                phase_next    = PH_TRIG;
                                cmd.trig_set1 = 1'b1;
                            end
                        end
                        PH_TRIG: begin
                            if (sts.trig_reached) begin
                                phase_next   = PH_WAIT;
                                cmd.trig_clr = 1'b1;
                            end else begin
                                cmd.trig_inc = 1'b1;
                            end
                        end
                        PH_WAIT: begin
                            if (s_data.echo_level) begin
                                phase_next    = PH_MEAS;
                                cmd.echo_set1 = 1'b1;
                            end
                        end
                        PH_MEAS: begin
                            if (s_data.echo_level) begin
                                cmd.echo_inc = 1'b1;
                            end else begin
                                // falling edge: distance goes through the divider
                                phase_next    = PH_IDLE;
                                cmd.div_start = 1'b1;
                                st_next       = ST_DIV;
                            end
                        end
                    endcase
                    if (!cmd.div_start) begin
                        cmd.out_load = 1'b1;
                        cmd.out_trig = (phase_next == PH_TRIG);
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.step_last) begin
                    st_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_start = 1'b1;
                st_next        = ST_BCD;
            end
            ST_BCD: begin
                cmd.bcd_step = 1'b1;
                if (sts.step_last) begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_done = 1'b1;
                    st_next      = ST_READY;
                end
            end
            default: begin
                st_next = ST_READY;
            end
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_READY;
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A new result is never written over one not yet taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> slot_free)
        else $error("result register overwritten");

    // While a distance is in flight the measurement is back in idle.
    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_READY |-> phase_reg == PH_IDLE)
        else $error("measurement phase moved during computation");

    // A falling echo in the measure phase starts the divider.
    a_fall_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_MEAS && !s_data.echo_level |=> st_reg == ST_DIV)
        else $error("completion did not start divider");

endmodule

>>> hdl/uer_dp.sv
module uer_dp
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  cfg_idx_t         cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    input  uer_cmd_t         cmd,
    output uer_sts_t         sts,
    output out_item_t        m_data
);

    localparam int NW = COUNT_BITS + 2;      // numerator 2*count + tpc
    localparam int DW = REG_W + 1;           // divisor 2*tpc
    localparam int CW = $clog2(NW);

    logic [REG_W-1:0]      trig_ticks_reg;
    logic [REG_W-1:0]      tpc_reg;
    logic [REG_W-1:0]      trig_cnt_reg;
    logic [COUNT_BITS-1:0] echo_cnt_reg;
    logic [NW-1:0]         quo_reg;
    logic [DW-1:0]         rem_reg;
    logic [CW-1:0]         step_reg;
    logic [DIST_W-1:0]     bin_reg;
    logic [11:0]           bcd_reg;
    logic                  ovf_pend_reg;
    logic [11:0]           shown_reg;
    logic                  ovf_reg;
    logic                  led_reg;
    out_item_t             out_reg;

    logic [REG_W-1:0] tpc_eff;
    logic [DW:0]      trial;
    logic [DW-1:0]    divisor;
    logic             q_bit;
    logic [DW-1:0]    rem_next;
    logic             sat;
    logic [11:0]      bcd_adj;
    logic [11:0]      digits_sel;

    assign tpc_eff = (tpc_reg == '0) ? REG_W'(1) : tpc_reg;
    assign divisor = {tpc_eff, 1'b0};
    assign trial   = {rem_reg, quo_reg[NW-1]};
    assign q_bit   = (trial >= {1'b0, divisor});
    assign rem_next = q_bit ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    assign sat     = (quo_reg > NW'(DIST_MAX));

    assign sts.trig_reached = (trig_cnt_reg >= trig_ticks_reg);
    assign sts.step_last    = (step_reg == '0);

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    assign digits_sel = cmd.commit ? bcd_reg : shown_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg <= TRIG_TICKS_RST;
            tpc_reg        <= TPC_RST;
            trig_cnt_reg   <= '0;
            echo_cnt_reg   <= '0;
            step_reg       <= '0;
            shown_reg      <= '0;
            ovf_reg        <= 1'b0;
            led_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TRIGGER_TICKS: trig_ticks_reg <= cfg_wdata;
                    REG_TICKS_PER_CM:  tpc_reg        <= cfg_wdata;
                endcase
            end
            if (cmd.trig_set1) begin
                trig_cnt_reg <= REG_W'(1);
            end else if (cmd.trig_clr) begin
                trig_cnt_reg <= '0;
            end else if (cmd.trig_inc) begin
                trig_cnt_reg <= trig_cnt_reg + REG_W'(1);
            end
            if (cmd.echo_set1) begin
                echo_cnt_reg <= COUNT_BITS'(1);
            end else if (cmd.echo_inc) begin
                echo_cnt_reg <= echo_cnt_reg + COUNT_BITS'(1);
            end
            if (cmd.div_start) begin
                step_reg <= CW'(NW - 1);
            end else if (cmd.conv_start) begin
                step_reg <= CW'(BCD_STEPS - 1);
            end else if (cmd.div_step || cmd.bcd_step) begin
                step_reg <= step_reg - CW'(1);
            end
            if (cmd.commit) begin
                shown_reg <= bcd_reg;
                ovf_reg   <= ovf_pend_reg;
                led_reg   <= 1'b1;
            end
        end
    end

    // divider, binary-to-BCD and result payload: no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg <= {1'b0, echo_cnt_reg, 1'b0} + NW'(tpc_eff);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[NW-2:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.conv_start) begin
            bin_reg      <= sat ? DIST_MAX : quo_reg[DIST_W-1:0];
            ovf_pend_reg <= sat;
            bcd_reg      <= '0;
        end else if (cmd.bcd_step) begin
            bcd_reg <= {bcd_adj[10:0], bin_reg[DIST_W-1]};
            bin_reg <= {bin_reg[DIST_W-2:0], 1'b0};
        end
        if (cmd.out_load) begin
            out_reg.trigger_level  <= cmd.out_trig;
            out_reg.digit_hundreds <= digits_sel[11:8];
            out_reg.digit_tens     <= digits_sel[7:4];
            out_reg.digit_ones     <= digits_sel[3:0];
            out_reg.done_res       <= cmd.out_done;
            out_reg.overflow       <= cmd.commit ? ovf_pend_reg : ovf_reg;
            out_reg.measured_led   <= cmd.commit | led_reg;
        end
    end

    assign m_data = out_reg;

    // Overflow is only ever set by a finished measurement.
    a_ovf_led: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> led_reg)
        else $error("overflow without a completed measurement");

    // Committed digits are always decimal.
    a_digits_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> bcd_reg[11:8] <= 4'd9 && bcd_reg[7:4] <= 4'd9
                       && bcd_reg[3:0] <= 4'd9)
        else $error("non-decimal digit committed");

endmodule

>>> hdl/ultrasonic_echo_ranger_unit.sv
// A tick that causes no completion gives its result in the cycle after its transfer.
// The completing tick (echo seen low) runs the bit-serial divider, a saturate step,
// the shift-add-3 steps and a commit step, which waits for a free result register.
// Throughput: one tick per cycle otherwise, while the receiver keeps taking results.
// Reset (aresetn low, synchronous): idle, counters and digits cleared,
// trigger_ticks = 160, ticks_per_cm = 928, no result pending.
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF   // echo counter width, 16 to 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write port
    input  logic             cfg_wr_en,
    input  cfg_idx_t         cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    // one item per timer tick
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    // one result per tick
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    // Controller sequences the measurement phases (idle, trigger, wait, measure)
    // and, after echo falls, walks the datapath through divide, saturate and
    // BCD conversion. The result register takes the next transfer as soon as
    // the previous one has been taken or is being taken in the same cycle.
    uer_cmd_t cmd;
    uer_sts_t sts;

    uer_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: config registers, trigger and echo counters, restoring
    // divider computing floor((2*count + tpc) / (2*tpc)) (round half up),
    // saturation to 999, shift-add-3 digit split, shown digits and flags.
    uer_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

>>> bench/ultrasonic_echo_ranger_unit_test.sv
module ultrasonic_echo_ranger_unit_test;
    import uer_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run limit, in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;
    // Cycles to let pass after the last result.
    localparam int SETTLE_CYCLES = 60;
    // Length of the long receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES = 300;
    // Echo counter width of the instance.
    localparam int ECHO_BITS = COUNT_BITS_DEF;

    // Measurement phases of the ranger, as the predictor tracks them.
    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_TRIG,
        RNG_WAIT,
        RNG_MEAS
    } ranger_phase_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    cfg_idx_t         cfg_index = REG_TRIGGER_TICKS;
    logic [REG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;

    ultrasonic_echo_ranger_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Ticks waiting to be offered, and readings waiting to come out.
    in_item_t  pending_ticks[$];
    out_item_t expected_readings[$];

    // Idling knobs, percent of cycles; set per phase by the stimulus process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long receiver hold-off: requested by the stimulus, counted down here.
    logic        hold_go   = 1'b0;
    int unsigned hold_left = 0;

    logic        tick_taken = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned ticks_seen = 0;
    int unsigned ranges_done = 0;
    int unsigned ranges_saturated = 0;
    int unsigned settings_used = 0;

    // Trigger length as the stimulus currently believes it, for shaping sequences.
    int unsigned cur_trig = TRIG_TICKS_RST;
    // Ticks queued in the current phase that do real work (idle filler excluded).
    int unsigned queued_work = 0;

    // ---------------------------------------------------------------
    // Predictor state: a shadow of the registers and of the ranger.
    // ---------------------------------------------------------------
    logic [15:0]          mirror_trig;
    logic [15:0]          mirror_tpc;
    ranger_phase_t        rng_phase;
    logic [15:0]          trig_cnt;
    logic [ECHO_BITS-1:0] echo_cnt;
    logic [3:0]           shown_h, shown_t, shown_o;
    logic                 ovf_flag;
    logic                 led_flag;

    // One timer tick through the ranger; returns the reading seen after it.
    function automatic out_item_t advance_ranger(input in_item_t t);
        out_item_t   r;
        logic [63:0] tpc64, span, quot;
        int unsigned cm;
        logic        done;
        done = 1'b0;
        case (rng_phase)
            RNG_IDLE: begin
                if (!t.start_n) begin
                    rng_phase = RNG_TRIG;
                    trig_cnt  = 16'd1;
                end
            end
            RNG_TRIG: begin
                // a zero length compares as done at once, i.e. one tick
                if (trig_cnt >= mirror_trig) begin
                    rng_phase = RNG_WAIT;
                    trig_cnt  = '0;
                end else begin
                    trig_cnt = trig_cnt + 16'd1;
                end
            end
            RNG_WAIT: begin
                if (t.echo_level) begin
                    rng_phase = RNG_MEAS;
                    echo_cnt  = ECHO_BITS'(1);
                end
            end
            default: begin
                if (t.echo_level) begin
                    echo_cnt = echo_cnt + 1'b1;   // wraps at the counter width
                end else begin
                    // round half up: floor((2c + p) / 2p), zero p taken as one
                    tpc64 = (mirror_tpc == 16'd0) ? 64'd1 : 64'(mirror_tpc);
                    span  = 64'(echo_cnt) * 2 + tpc64;
                    quot  = span / (tpc64 * 2);
                    if (quot > 64'd999) begin
                        cm       = 999;
                        ovf_flag = 1'b1;
                    end else begin
                        cm       = int'(quot);
                        ovf_flag = 1'b0;
                    end
                    shown_h   = 4'(cm / 100);
                    shown_t   = 4'((cm / 10) % 10);
                    shown_o   = 4'(cm % 10);
                    led_flag  = 1'b1;
                    done      = 1'b1;
                    rng_phase = RNG_IDLE;
                end
            end
        endcase
        r.trigger_level  = (rng_phase == RNG_TRIG);
        r.digit_hundreds = shown_h;
        r.digit_tens     = shown_t;
        r.digit_ones     = shown_o;
        r.done_res       = done;
        r.overflow       = ovf_flag;
        r.measured_led   = led_flag;
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        $display("mismatch @%0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            log_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
    endtask

    task automatic compare_reading(input out_item_t got, input out_item_t want);
        check_field("trigger_level",  got.trigger_level,  want.trigger_level);
        check_field("digit_hundreds", got.digit_hundreds, want.digit_hundreds);
        check_field("digit_tens",     got.digit_tens,     want.digit_tens);
        check_field("digit_ones",     got.digit_ones,     want.digit_ones);
        check_field("done_res",       got.done_res,       want.done_res);
        check_field("overflow",       got.overflow,       want.overflow);
        check_field("measured_led",   got.measured_led,   want.measured_led);
    endtask

    // ---------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. Register writes
    // go into the shadow, accepted ticks into the predictor, and each
    // result transfer is checked against the oldest expected reading.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_taken  <= 1'b0;
            mirror_trig = TRIG_TICKS_RST;
            mirror_tpc  = TPC_RST;
            rng_phase   = RNG_IDLE;
            trig_cnt    = '0;
            echo_cnt    = '0;
            shown_h     = '0;
            shown_t     = '0;
            shown_o     = '0;
            ovf_flag    = 1'b0;
            led_flag    = 1'b0;
        end else begin
            tick_taken <= s_valid && s_ready;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TRIGGER_TICKS: mirror_trig = cfg_wdata;
                    REG_TICKS_PER_CM:  mirror_tpc  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_readings.push_back(advance_ranger(s_data));
                ticks_seen++;
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    log_mismatch("result transfer with no reading expected");
                end else begin
                    compare_reading(m_data, expected_readings[0]);
                    if (expected_readings[0].done_res) begin
                        ranges_done++;
                        if (expected_readings[0].overflow)
                            ranges_saturated++;
                    end
                    void'(expected_readings.pop_front());
                end
            end
        end
    end

    // Driver: offers the next queued tick on the falling edge; a tick stays
    // put until its transfer, and gaps are inserted only between ticks.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_ticks.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, forced low while a hold-off runs.
    always @(negedge aclk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold-off counter, in its own process.
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_tick(input logic start_n, input logic echo);
        in_item_t t;
        t.start_n    = start_n;
        t.echo_level = echo;
        pending_ticks.push_back(t);
    endtask

    // One well-formed measurement: idle filler, a press, the trigger ticks
    // (echo is don't-care there), a wait with echo low, high_n ticks of echo
    // and the falling tick. With held set the button stays pressed through the
    // echo ticks and the falling tick.
    task automatic queue_range(input int unsigned idle_n, input int unsigned wait_n,
                               input int unsigned high_n, input bit held);
        int unsigned trig_n;
        trig_n = (cur_trig == 0) ? 1 : cur_trig;
        repeat (idle_n) push_tick(1'b1, 1'($urandom));
        push_tick(1'b0, 1'($urandom));
        repeat (trig_n) push_tick(1'($urandom), 1'($urandom));
        repeat (wait_n) push_tick(1'($urandom), 1'b0);
        repeat (high_n) push_tick(held ? 1'b0 : 1'($urandom), 1'b1);
        push_tick(held ? 1'b0 : 1'($urandom), 1'b0);
        queued_work += 2 + trig_n + wait_n + high_n;
    endtask

    // Registers are only touched with nothing in flight.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_valid || expected_readings.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_ranger(input logic [15:0] trig, input logic [15:0] tpc);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TRIGGER_TICKS;
        cfg_wdata <= trig;
        @(negedge aclk);
        cfg_index <= REG_TICKS_PER_CM;
        cfg_wdata <= tpc;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_trig = trig;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_tpc();
        case ($urandom_range(3))
            0:       return 16'd1;
            1:       return 16'($urandom_range(2, 12));
            2:       return 16'($urandom_range(13, 64));
            default: return TPC_RST;
        endcase
    endfunction

    function automatic int unsigned pick_echo_len();
        if ($urandom_range(99) < 80)
            return $urandom_range(1, 40);
        return $urandom_range(100, 300);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset registers (160 / 928): a short echo rounds down to 0 cm.
        // Idle ticks with echo toggling are ignored.
        queue_range(3, 2, 10, 1'b0);
        wait_drained();

        // Zero trigger length and zero ticks per cm both act as one;
        // button held across completion restarts at once.
        set_ranger(16'd0, 16'd0);
        queue_range(2, 1, 3, 1'b1);
        queue_range(0, 0, 1, 1'b0);
        wait_drained();

        // Half-up rounding, and a rounding carry through tens into hundreds
        // (199/2 = 99.5 -> 100), after a long wait for the echo to rise.
        set_ranger(16'd1, 16'd2);
        queue_range(1, 0, 5, 1'b0);
        queue_range(0, 30, 199, 1'b0);
        wait_drained();

        // Saturation to 999 with overflow, then overflow cleared again.
        set_ranger(16'd2, 16'd1);
        queue_range(1, 0, 1000, 1'b0);
        queue_range(1, 0, 7, 1'b0);
        wait_drained();

        // Largest register values: start a trigger pulse that would last
        // 65535 ticks, then shorten it while the pulse runs.
        set_ranger(16'hFFFF, 16'hFFFF);
        push_tick(1'b0, 1'b1);
        repeat (20) push_tick(1'($urandom), 1'($urandom));
        wait_drained();
        set_ranger(16'd3, 16'hFFFF);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        repeat (40) push_tick(1'($urandom), 1'b1);
        push_tick(1'b1, 1'b0);
        wait_drained();

        // Random phases, one per idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            set_ranger(16'($urandom_range(1, 6)), pick_tpc());
            queued_work = 0;
            while (queued_work < 50) begin
                if ($urandom_range(99) < 15) begin
                    // noise: any level on either line, may break a sequence
                    for (int n = $urandom_range(1, 12); n > 0; n--) begin
                        push_tick(1'($urandom), 1'($urandom));
                        queued_work++;
                    end
                end else begin
                    queue_range($urandom_range(0, 3), $urandom_range(0, 4),
                                pick_echo_len(), $urandom_range(9) == 0);
                end
            end
            if (ph == 0) begin
                // receiver backs off while the sender keeps offering ticks
                @(negedge aclk);
                hold_go <= 1'b1;
                @(negedge aclk);
                hold_go <= 1'b0;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_readings.size() != 0)
            log_mismatch("readings still expected at end of run");

        $display("ticks: %0d over %0d register settings, idling on either side and none",
                 ticks_seen, settings_used);
        $display("ranges completed: %0d, saturated: %0d, mismatches: %0d",
                 ranges_done, ranges_saturated, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
